### hdl/izn_pkg.sv
// ----------------------------------------------------------------------------
// izn_pkg: shared types and constants of the Izhikevich neuron step block
// Holds widths, register codes, reset values, fixed-point step constants and
// the structs passed between the configuration, pipeline and memory parts.
// ----------------------------------------------------------------------------
package izn_pkg;

  // Neuron store geometry
  localparam int NEURONS   = 1024;
  localparam int NEURON_AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  // Field widths
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Register stages from the memory read to the output register
  localparam int PIPE_DEPTH = 7;

  // Configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REST       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VRESET     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PEAK       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_JUMP       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = CFG_IDX_W'(5);

  // Register reset values, Q16.16 millivolts
  localparam logic [DATA_W-1:0] THRESHOLD_RST  = -32'sd3604480;  // -55 mV
  localparam logic [DATA_W-1:0] REST_RST       = -32'sd4718592;  // -72 mV
  localparam logic [DATA_W-1:0] VRESET_RST     = -32'sd5242880;  // -80 mV
  localparam logic [DATA_W-1:0] PEAK_RST       = 32'sd2293760;   //  35 mV
  localparam logic [DATA_W-1:0] JUMP_RST       = 32'sd393216;    //   6
  localparam logic [CNT_W-1:0]  REFRACTORY_RST = 8'd120;

  // Potential of every neuron after reset (-72 mV)
  localparam logic [DATA_W-1:0] V_INIT = -32'sd4718592;

  // Euler step coefficients scaled by 2^32 (dt = 0.025 ms)
  localparam int K1_W = 20;
  localparam int K2_W = 21;
  localparam int K3_W = 19;
  localparam int K4_W = 22;
  localparam logic [K1_W-1:0] K1 = 20'd751619;   // dt*k/C
  localparam logic [K2_W-1:0] K2 = 21'd1073742;  // dt/C
  localparam logic [K3_W-1:0] K3 = 19'd429497;   // dt*a*b
  localparam logic [K4_W-1:0] K4 = 22'd2147484;  // dt*a

  typedef struct packed {
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] rest;
    logic [DATA_W-1:0] vreset;
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] jump;
    logic [CNT_W-1:0]  refr;
  } cfg_t;

  // One neuron's stored state
  typedef struct packed {
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] u;
    logic [CNT_W-1:0]  cnt;
  } nrn_state_t;

  typedef struct packed {
    logic                 en;
    logic [NEURON_AW-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                 en;
    logic [NEURON_AW-1:0] addr;
    nrn_state_t           data;
  } ram_wr_t;

endpackage

### hdl/izn_ram.sv
// ----------------------------------------------------------------------------
// izn_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module izn_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/izn_cfg.sv
// ----------------------------------------------------------------------------
// izn_cfg: configuration registers of the neuron step block
// Decodes the write port into the six model registers.
// ----------------------------------------------------------------------------
module izn_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [izn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [izn_pkg::DATA_W-1:0]     cfg_wdata_i,
  output izn_pkg::cfg_t                  cfg_o
);

  izn_pkg::cfg_t cfg_q;

  // Load the addressed register, drop writes to unused codes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr    <= izn_pkg::THRESHOLD_RST;
      cfg_q.rest   <= izn_pkg::REST_RST;
      cfg_q.vreset <= izn_pkg::VRESET_RST;
      cfg_q.peak   <= izn_pkg::PEAK_RST;
      cfg_q.jump   <= izn_pkg::JUMP_RST;
      cfg_q.refr   <= izn_pkg::REFRACTORY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        izn_pkg::REG_THRESHOLD:  cfg_q.thr    <= cfg_wdata_i;
        izn_pkg::REG_REST:       cfg_q.rest   <= cfg_wdata_i;
        izn_pkg::REG_VRESET:     cfg_q.vreset <= cfg_wdata_i;
        izn_pkg::REG_PEAK:       cfg_q.peak   <= cfg_wdata_i;
        izn_pkg::REG_JUMP:       cfg_q.jump   <= cfg_wdata_i;
        izn_pkg::REG_REFRACTORY: cfg_q.refr   <= cfg_wdata_i[izn_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/izn_pipe.sv
// ----------------------------------------------------------------------------
// izn_pipe: seven-stage update pipeline of the neuron step block
// Stage 0 holds the memory read, stages 1 to 5 do the Euler step arithmetic,
// stage 6 is the output register. The state write happens as an item enters
// stage 6. Items whose neuron is still in flight wait at the input.
// ----------------------------------------------------------------------------
module izn_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  izn_pkg::cfg_t                cfg_i,
  input  logic                         hold_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [izn_pkg::IDX_W-1:0]    neuron_index_i,
  output izn_pkg::ram_rd_t             rd_o,
  input  izn_pkg::nrn_state_t          rd_data_i,
  output izn_pkg::ram_wr_t             wr_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [izn_pkg::IDX_W-1:0]    neuron_id_o,
  output logic                         spiked_o,
  output logic [izn_pkg::DATA_W-1:0]   membrane_potential_o,
  output logic [izn_pkg::DATA_W-1:0]   recovery_value_o
);

  localparam int DEPTH = izn_pkg::PIPE_DEPTH;

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] u;
    logic [7:0]  cnt;
    logic        sgn1;
    logic        neg_dv;
    logic        neg_u;
    logic [31:0] mag_dv;
    logic [31:0] mag_dt;
    logic [31:0] mag_u;
  } st1_t;

  typedef struct packed {
    logic [31:0]               v;
    logic [31:0]               u;
    logic [7:0]                cnt;
    logic                      sgn1;
    logic                      neg_dv;
    logic                      neg_u;
    logic [63:0]               m;
    logic [izn_pkg::K2_W-1:0]  t2mag;
    logic [izn_pkg::K3_W-1:0]  t3mag;
    logic [izn_pkg::K4_W-1:0]  t4mag;
  } st2_t;

  typedef struct packed {
    logic [7:0]                cnt;
    logic                      sgn1;
    logic [32+izn_pkg::K1_W-1:0] ph;
    logic [izn_pkg::K1_W-1:0]  pl_hi;
    logic [32:0]               vpart;
    logic [32:0]               upart;
    logic [izn_pkg::K3_W:0]    t3s;
    logic [31:0]               uj;
  } st3_t;

  typedef struct packed {
    logic [7:0]  cnt;
    logic        sgn1;
    logic [35:0] t1mag;
    logic [32:0] vpart;
    logic [31:0] un;
    logic [31:0] uj;
  } st4_t;

  typedef struct packed {
    logic [7:0]  cnt;
    logic [31:0] vn;
    logic [31:0] un;
    logic [31:0] uj;
  } st5_t;

  typedef struct packed {
    logic        spk;
    logic [31:0] v;
    logic [31:0] u;
  } out_t;

  // Clamp a wide signed sum to the 32-bit range
  function automatic logic [31:0] sat32(input logic [37:0] x);
    logic [31:0] r;
    if (x[37:31] == {7{x[31]}}) begin
      r = x[31:0];
    end else if (x[37]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic [DEPTH-1:0]          vld_q;
  logic [DEPTH-1:0]          rdy;
  logic [izn_pkg::IDX_W-1:0] idx_q [DEPTH];
  logic                      inr_q [DEPTH];
  logic                      hit;
  logic                      acc;
  logic                      in_range;

  st1_t st1_d, st1_q;
  st2_t st2_d, st2_q;
  st3_t st3_d, st3_q;
  st4_t st4_d, st4_q;
  st5_t st5_d, st5_q;
  out_t out_d, out_q;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    rdy[DEPTH-1] = !vld_q[DEPTH-1] || !out_stall_i;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // Hold an item whose neuron is still being updated further down
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (vld_q[k] && (idx_q[k] == neuron_index_i)) begin
        hit = 1'b1;
      end
    end
  end

  assign in_stall_o = hold_i || hit || !rdy[0];
  assign acc        = in_valid_i && !in_stall_o;
  assign in_range   = (32'(neuron_index_i) < 32'(izn_pkg::NEURONS));

  assign rd_o.en   = acc;
  assign rd_o.addr = izn_pkg::NEURON_AW'(neuron_index_i);

  // Valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= acc;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Index and range flag of each stage
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      idx_q[0] <= neuron_index_i;
      inr_q[0] <= in_range;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (rdy[k]) begin
        idx_q[k] <= idx_q[k-1];
        inr_q[k] <= inr_q[k-1];
      end
    end
  end

  // Stage 1: distances to rest and threshold as sign and magnitude
  logic signed [32:0] dv_fwd, dv_rev, dt_fwd, dt_rev;

  always_comb begin
    dv_fwd = 33'(signed'(rd_data_i.v)) - 33'(signed'(cfg_i.rest));
    dv_rev = 33'(signed'(cfg_i.rest)) - 33'(signed'(rd_data_i.v));
    dt_fwd = 33'(signed'(rd_data_i.v)) - 33'(signed'(cfg_i.thr));
    dt_rev = 33'(signed'(cfg_i.thr)) - 33'(signed'(rd_data_i.v));
    st1_d.v      = rd_data_i.v;
    st1_d.u      = rd_data_i.u;
    st1_d.cnt    = rd_data_i.cnt;
    st1_d.neg_dv = dv_fwd[32];
    st1_d.sgn1   = dv_fwd[32] ^ dt_fwd[32];
    st1_d.mag_dv = dv_fwd[32] ? dv_rev[31:0] : dv_fwd[31:0];
    st1_d.mag_dt = dt_fwd[32] ? dt_rev[31:0] : dt_fwd[31:0];
    st1_d.neg_u  = rd_data_i.u[31];
    st1_d.mag_u  = rd_data_i.u[31] ? (32'd0 - rd_data_i.u) : rd_data_i.u;
  end

  // Stage 2: quadratic product and the three linear scalings
  logic [31+izn_pkg::K2_W:0] p_t2;
  logic [31+izn_pkg::K3_W:0] p_t3;
  logic [31+izn_pkg::K4_W:0] p_t4;

  always_comb begin
    p_t2 = (32+izn_pkg::K2_W)'(st1_q.mag_u) * (32+izn_pkg::K2_W)'(izn_pkg::K2);
    p_t3 = (32+izn_pkg::K3_W)'(st1_q.mag_dv) * (32+izn_pkg::K3_W)'(izn_pkg::K3);
    p_t4 = (32+izn_pkg::K4_W)'(st1_q.mag_u) * (32+izn_pkg::K4_W)'(izn_pkg::K4);
    st2_d.v      = st1_q.v;
    st2_d.u      = st1_q.u;
    st2_d.cnt    = st1_q.cnt;
    st2_d.sgn1   = st1_q.sgn1;
    st2_d.neg_dv = st1_q.neg_dv;
    st2_d.neg_u  = st1_q.neg_u;
    st2_d.m      = 64'(st1_q.mag_dv) * 64'(st1_q.mag_dt);
    st2_d.t2mag  = p_t2[31+izn_pkg::K2_W:32];
    st2_d.t3mag  = p_t3[31+izn_pkg::K3_W:32];
    st2_d.t4mag  = p_t4[31+izn_pkg::K4_W:32];
  end

  // Stage 3: split scaling of the quadratic term, partial V and U sums
  logic [31+izn_pkg::K1_W:0] p_lo;
  logic signed [32:0]        v_ext, u_ext, uj_sum;
  logic [izn_pkg::K3_W:0]    t3z;

  always_comb begin
    p_lo   = (32+izn_pkg::K1_W)'(st2_q.m[31:0]) * (32+izn_pkg::K1_W)'(izn_pkg::K1);
    v_ext  = 33'(signed'(st2_q.v));
    u_ext  = 33'(signed'(st2_q.u));
    uj_sum = u_ext + 33'(signed'(cfg_i.jump));
    t3z    = (izn_pkg::K3_W+1)'(st2_q.t3mag);
    st3_d.cnt   = st2_q.cnt;
    st3_d.sgn1  = st2_q.sgn1;
    st3_d.ph    = (32+izn_pkg::K1_W)'(st2_q.m[63:32]) * (32+izn_pkg::K1_W)'(izn_pkg::K1);
    st3_d.pl_hi = p_lo[31+izn_pkg::K1_W:32];
    st3_d.vpart = st2_q.neg_u ? (v_ext + 33'(st2_q.t2mag)) : (v_ext - 33'(st2_q.t2mag));
    st3_d.upart = st2_q.neg_u ? (u_ext + 33'(st2_q.t4mag)) : (u_ext - 33'(st2_q.t4mag));
    st3_d.t3s   = st2_q.neg_dv ? ((izn_pkg::K3_W+1)'(0) - t3z) : t3z;
    st3_d.uj    = sat32(38'(uj_sum));
  end

  // Stage 4: finish the quadratic term, saturate the new recovery
  logic [31+izn_pkg::K1_W:0] t1_sum;
  logic signed [33:0]        un_sum;

  always_comb begin
    t1_sum = st3_q.ph + (32+izn_pkg::K1_W)'(st3_q.pl_hi);
    un_sum = 34'(signed'(st3_q.upart)) + 34'(signed'(st3_q.t3s));
    st4_d.cnt   = st3_q.cnt;
    st4_d.sgn1  = st3_q.sgn1;
    st4_d.t1mag = t1_sum[51:16];
    st4_d.vpart = st3_q.vpart;
    st4_d.un    = sat32(38'(un_sum));
    st4_d.uj    = st3_q.uj;
  end

  // Stage 5: add the signed quadratic term and saturate the potential
  logic signed [37:0] vp_ext, vn_sum;

  always_comb begin
    vp_ext = 38'(signed'(st4_q.vpart));
    vn_sum = st4_q.sgn1 ? (vp_ext - 38'(st4_q.t1mag)) : (vp_ext + 38'(st4_q.t1mag));
    st5_d.cnt = st4_q.cnt;
    st5_d.vn  = sat32(vn_sum);
    st5_d.un  = st4_q.un;
    st5_d.uj  = st4_q.uj;
  end

  // Stage 6: clamp, peak substitution, spike decision and state write
  logic signed [31:0]  vn_s, thr_s, vrst_s, peak_s;
  logic                ge_thr, lt_rst, peak_ok, spike;
  izn_pkg::nrn_state_t nxt;

  always_comb begin
    vn_s    = signed'(st5_q.vn);
    thr_s   = signed'(cfg_i.thr);
    vrst_s  = signed'(cfg_i.vreset);
    peak_s  = signed'(cfg_i.peak);
    ge_thr  = (vn_s >= thr_s) || (vrst_s >= thr_s);
    lt_rst  = vn_s < vrst_s;
    peak_ok = peak_s >= thr_s;
    spike   = ge_thr && peak_ok && (st5_q.cnt == '0);
    if (spike) begin
      nxt.v   = cfg_i.vreset;
      nxt.u   = st5_q.uj;
      nxt.cnt = cfg_i.refr;
    end else begin
      nxt.v   = ge_thr ? cfg_i.peak : (lt_rst ? cfg_i.vreset : st5_q.vn);
      nxt.u   = st5_q.un;
      nxt.cnt = (st5_q.cnt == '0) ? st5_q.cnt : (st5_q.cnt - 8'd1);
    end
    // Report zeros for an index beyond the store
    if (inr_q[DEPTH-2]) begin
      out_d.spk = spike;
      out_d.v   = nxt.v;
      out_d.u   = nxt.u;
    end else begin
      out_d = '0;
    end
  end

  assign wr_o.en   = vld_q[DEPTH-2] && rdy[DEPTH-1] && inr_q[DEPTH-2];
  assign wr_o.addr = izn_pkg::NEURON_AW'(idx_q[DEPTH-2]);
  assign wr_o.data = nxt;

  // Stage payload registers
  always_ff @(posedge clk_i) begin
    if (rdy[1]) st1_q <= st1_d;
    if (rdy[2]) st2_q <= st2_d;
    if (rdy[3]) st3_q <= st3_d;
    if (rdy[4]) st4_q <= st4_d;
    if (rdy[5]) st5_q <= st5_d;
    if (rdy[6]) out_q <= out_d;
  end

  assign out_valid_o          = vld_q[DEPTH-1];
  assign neuron_id_o          = idx_q[DEPTH-1];
  assign spiked_o             = out_q.spk;
  assign membrane_potential_o = out_q.v;
  assign recovery_value_o     = out_q.u;

endmodule

### hdl/izhikevich_neuron_step.sv
// ----------------------------------------------------------------------------
// izhikevich_neuron_step: one Euler step of the Izhikevich neuron per item
// Input items carry a neuron index. Result items return the index, the spike
// flag and the stored potential and recovery after the step. Both channels
// use valid/stall; an item moves on a clock edge with valid high, stall low.
// Registers are written through a plain write port (enable, index, data). The
// user must write them only while no item is in flight; it is not enforced.
// Pipeline: the memory read register loads at the accepting edge, then five
// arithmetic stages and one output register follow before output valid.
// Throughput: one item per cycle while the output is not stalled. An item
// whose neuron is still in the pipeline waits at the input until that update
// is written back, since the neuron state memory is read at entry and written
// at the last arithmetic stage.
// Reset: registers take their defaults and the neuron store is initialized
// one entry per cycle over the whole store, with the input stalled meanwhile.
// Output stall: the pipeline closes its bubbles and then holds; no item is
// lost or repeated.
// ----------------------------------------------------------------------------
module izhikevich_neuron_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [izn_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [izn_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [izn_pkg::IDX_W-1:0]         neuron_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [izn_pkg::IDX_W-1:0]         neuron_id_o,
  output logic                              spiked_o,
  output logic signed [izn_pkg::DATA_W-1:0] membrane_potential_o,
  output logic signed [izn_pkg::DATA_W-1:0] recovery_value_o
);

  izn_pkg::cfg_t                  cfg;
  izn_pkg::ram_rd_t               pipe_rd;
  izn_pkg::ram_wr_t               pipe_wr;
  izn_pkg::ram_wr_t               ram_wr;
  izn_pkg::nrn_state_t            rd_state;
  logic [$bits(izn_pkg::nrn_state_t)-1:0] rd_data;
  logic                           clr_busy_q;
  logic [izn_pkg::NEURON_AW-1:0]  clr_addr_q;

  izn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sweep the store with the initial state after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == izn_pkg::NEURON_AW'(izn_pkg::NEURONS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + izn_pkg::NEURON_AW'(1);
    end
  end

  // Give the write port to the sweep while it runs
  always_comb begin
    if (clr_busy_q) begin
      ram_wr.en       = 1'b1;
      ram_wr.addr     = clr_addr_q;
      ram_wr.data.v   = izn_pkg::V_INIT;
      ram_wr.data.u   = '0;
      ram_wr.data.cnt = '0;
    end else begin
      ram_wr = pipe_wr;
    end
  end

  izn_ram #(
    .WIDTH ($bits(izn_pkg::nrn_state_t)),
    .DEPTH (izn_pkg::NEURONS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr.en),
    .wr_addr_i (ram_wr.addr),
    .wr_data_i (ram_wr.data),
    .rd_en_i   (pipe_rd.en),
    .rd_addr_i (pipe_rd.addr),
    .rd_data_o (rd_data)
  );

  assign rd_state = rd_data;

  izn_pipe u_pipe (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .hold_i               (clr_busy_q),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .neuron_index_i       (neuron_index_i),
    .rd_o                 (pipe_rd),
    .rd_data_i            (rd_state),
    .wr_o                 (pipe_wr),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .neuron_id_o          (neuron_id_o),
    .spiked_o             (spiked_o),
    .membrane_potential_o (membrane_potential_o),
    .recovery_value_o     (recovery_value_o)
  );

endmodule

### hdl/izn_checker.sv
// ----------------------------------------------------------------------------
// izn_checker: port-level checks of the neuron step block
// Tracks items in flight and checks that no result comes without an input, that
// the count stays within the pipeline depth and that output holds under stall.
// ----------------------------------------------------------------------------
module izn_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [izn_pkg::IDX_W-1:0]         neuron_id_o,
  input logic                              spiked_o,
  input logic signed [izn_pkg::DATA_W-1:0] membrane_potential_o,
  input logic signed [izn_pkg::DATA_W-1:0] recovery_value_o
);

  localparam int CNT_W = $clog2(izn_pkg::PIPE_DEPTH + 1) + 1;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_d, inflight_q;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign inflight_d = inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result only for an item that went in
  a_no_invented_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("result item without an accepted input item");

  // The pipeline never holds more items than it has stages
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(izn_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // Output valid holds under stall
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // Output payload holds under stall
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(neuron_id_o) && $stable(spiked_o)
      && $stable(membrane_potential_o) && $stable(recovery_value_o)))
    else $error("output payload changed while stalled");

endmodule

bind izhikevich_neuron_step izn_checker u_izn_checker (.*);

### dv/izhikevich_neuron_step_tb.sv
// ----------------------------------------------------------------------------
// izhikevich_neuron_step_tb: self-checking bench for the neuron step block
// Drives neuron indexes into the block under a series of register settings.
// The settings include the defaults, spike-forcing thresholds, a peak below
// threshold and full-scale extremes. A scoreboard keeps its own copy of every
// neuron's potential, recovery and refractory count and predicts each result.
// Results are compared field by field, in order. Random gaps on both sides
// and long output holds exercise the valid/stall flow control.
// ----------------------------------------------------------------------------
module izhikevich_neuron_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MV            = 65536;           // one millivolt in Q16.16
  localparam int WORD_MIN      = 32'sh8000_0000;
  localparam int WORD_MAX      = 32'sh7FFF_FFFF;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 92;
  localparam int POOL_SIZE     = 8;

  // Indexes past the last register, which the block must ignore
  localparam logic [izn_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = izn_pkg::CFG_IDX_W'(6);
  localparam logic [izn_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = izn_pkg::CFG_IDX_W'(7);

  typedef struct packed {
    logic [izn_pkg::IDX_W-1:0]  neuron_id;
    logic                       spiked;
    logic [izn_pkg::DATA_W-1:0] potential;
    logic [izn_pkg::DATA_W-1:0] recovery;
  } step_result_t;

  // Tracks neuron state and register values, predicts and checks results
  class neuron_scoreboard;
    int thr, rest, vreset, peak, jump, refr;
    int potential_mem[izn_pkg::NEURONS];
    int recovery_mem[izn_pkg::NEURONS];
    int refr_left[izn_pkg::NEURONS];
    step_result_t expected_steps[$];
    int checked, spikes, failures;

    function new();
      thr    = izn_pkg::THRESHOLD_RST;
      rest   = izn_pkg::REST_RST;
      vreset = izn_pkg::VRESET_RST;
      peak   = izn_pkg::PEAK_RST;
      jump   = izn_pkg::JUMP_RST;
      refr   = izn_pkg::REFRACTORY_RST;
      foreach (potential_mem[i]) begin
        potential_mem[i] = izn_pkg::V_INIT;
        recovery_mem[i]  = 0;
        refr_left[i]     = 0;
      end
    endfunction

    function void set_reg(logic [izn_pkg::CFG_IDX_W-1:0] idx,
                          logic [izn_pkg::DATA_W-1:0] data);
      case (idx)
        izn_pkg::REG_THRESHOLD:  thr = data;
        izn_pkg::REG_REST:       rest = data;
        izn_pkg::REG_VRESET:     vreset = data;
        izn_pkg::REG_PEAK:       peak = data;
        izn_pkg::REG_JUMP:       jump = data;
        izn_pkg::REG_REFRACTORY: refr = data[izn_pkg::CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint x);
      if (x > longint'(WORD_MAX)) return longint'(WORD_MAX);
      if (x < longint'(WORD_MIN)) return longint'(WORD_MIN);
      return x;
    endfunction

    function bit [63:0] mag_of(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // Exact mag*k / 2^sh truncated toward zero, sign applied afterwards
    function longint scale_trunc(bit neg, bit [63:0] mag, bit [31:0] k, int sh);
      bit [127:0] prod;
      prod = 128'(mag) * 128'(k);
      prod = prod >> sh;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Advance one neuron by an Euler step and queue the expected result
    function void advance_neuron(logic [izn_pkg::IDX_W-1:0] idx);
      step_result_t r;
      longint v, u, dv, dt, t1, vn, un;
      bit fire;
      r = '0;
      r.neuron_id = idx;
      if (idx < izn_pkg::NEURONS) begin
        v  = potential_mem[idx];
        u  = recovery_mem[idx];
        dv = v - rest;
        dt = v - thr;
        t1 = scale_trunc((dv < 0) != (dt < 0), mag_of(dv) * mag_of(dt), izn_pkg::K1, 48);
        vn = clamp_word(v + t1 - scale_trunc(u < 0, mag_of(u), izn_pkg::K2, 32));
        un = clamp_word(u + scale_trunc(dv < 0, mag_of(dv), izn_pkg::K3, 32)
                          - scale_trunc(u < 0, mag_of(u), izn_pkg::K4, 32));
        // clamp low, then replace with the peak once at threshold
        if (vn < vreset) vn = vreset;
        if (vn >= thr) vn = peak;
        fire = (vn >= thr) && (refr_left[idx] == 0);
        if (fire) begin
          potential_mem[idx] = vreset;
          recovery_mem[idx]  = int'(clamp_word(u + jump));
          refr_left[idx]     = refr;
          spikes++;
        end else begin
          potential_mem[idx] = int'(vn);
          recovery_mem[idx]  = int'(un);
          if (refr_left[idx] > 0) refr_left[idx]--;
        end
        r.spiked    = fire;
        r.potential = potential_mem[idx];
        r.recovery  = recovery_mem[idx];
      end
      expected_steps.push_back(r);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected result for neuron %0d", $time, got.neuron_id);
        return;
      end
      want = expected_steps.pop_front();
      checked++;
      if (got.neuron_id !== want.neuron_id || got.spiked !== want.spiked ||
          got.potential !== want.potential || got.recovery !== want.recovery) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] mismatch: expected id %0d spike %0b v %h u %h", $time,
                   want.neuron_id, want.spiked, want.potential, want.recovery);
          $display("[%0t]           actual   id %0d spike %0b v %h u %h", $time,
                   got.neuron_id, got.spiked, got.potential, got.recovery);
        end
      end
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [izn_pkg::CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [izn_pkg::DATA_W-1:0]        cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [izn_pkg::IDX_W-1:0]         neuron_index = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [izn_pkg::IDX_W-1:0]         neuron_id;
  logic                              spiked;
  logic signed [izn_pkg::DATA_W-1:0] membrane_potential;
  logic signed [izn_pkg::DATA_W-1:0] recovery_value;

  neuron_scoreboard steps_sb = new;
  logic [izn_pkg::IDX_W-1:0] pool[POOL_SIZE];
  int settings;

  izhikevich_neuron_step dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .neuron_index_i       (neuron_index),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .neuron_id_o          (neuron_id),
    .spiked_o             (spiked),
    .membrane_potential_o (membrane_potential),
    .recovery_value_o     (recovery_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_potential();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return int'($urandom());
      default: return int'($urandom_range(0, 150 * MV)) - 100 * MV;
    endcase
  endfunction

  function automatic int pick_refractory();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Stay on a few neurons so they run through many steps in a row
  function automatic logic [izn_pkg::IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 75) return pool[$urandom_range(0, POOL_SIZE - 1)];
    return izn_pkg::IDX_W'($urandom_range(0, izn_pkg::NEURONS - 1));
  endfunction

  task automatic send_index(logic [izn_pkg::IDX_W-1:0] idx);
    bit taken;
    in_valid     <= 1'b1;
    neuron_index <= idx;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    steps_sb.advance_neuron(idx);
  endtask

  task automatic write_reg(logic [izn_pkg::CFG_IDX_W-1:0] idx,
                           logic [izn_pkg::DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    steps_sb.set_reg(idx, data);
  endtask

  // Drain the pipeline, then write every register and both spare indexes
  task automatic load_registers(int thr, int rest, int vreset, int peak, int jump,
                                int refr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (steps_sb.pending() != 0) @(posedge clk);
    repeat (izn_pkg::PIPE_DEPTH + 2) @(posedge clk);
    write_reg(izn_pkg::REG_THRESHOLD, thr);
    write_reg(izn_pkg::REG_REST, rest);
    write_reg(izn_pkg::REG_VRESET, vreset);
    write_reg(izn_pkg::REG_PEAK, peak);
    write_reg(izn_pkg::REG_JUMP, jump);
    write_reg(izn_pkg::REG_REFRACTORY, {24'($urandom()), 8'(refr)});
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(int count);
    bit burst, drain;
    int gap;
    burst = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      gap = 0;
      if (!burst && $urandom_range(0, 99) < 30) gap = idle_len();
      drain = ($urandom_range(0, 149) == 0);
      if (drain && gap == 0) gap = 1;
      // hold off, and on a drain wait until every result is back
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (drain) while (steps_sb.pending() != 0) @(posedge clk);
      end
      send_index(pick_index());
    end
  endtask

  // Result side: random stalls, quiet stretches and two long holds
  initial begin : result_sink
    int stall_left, quiet_left, long_holds;
    step_result_t got;
    stall_left = 0;
    quiet_left = 0;
    long_holds = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && long_holds < 2 &&
          steps_sb.checked >= 250 + 900 * long_holds) begin
        stall_left = 150;
        long_holds++;
      end else if (stall_left == 0) begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 99) < 20) stall_left = idle_len();
        else if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(50, 300);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(negedge clk);
      if (out_valid && !out_stall) begin
        got.neuron_id = neuron_id;
        got.spiked    = spiked;
        got.potential = membrane_potential;
        got.recovery  = recovery_value;
        steps_sb.check_result(got);
      end
    end
  end

  initial begin : stimulus
    logic [izn_pkg::IDX_W-1:0] corner_idx[6];
    corner_idx = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd3, 10'd3};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: neurons at rest stay there; index extremes and a back-to-back repeat
    foreach (corner_idx[i]) send_index(corner_idx[i]);

    // threshold below rest: spike, then refractory steps that store the peak
    load_registers(-80 * MV, -72 * MV, -80 * MV, 35 * MV, 6 * MV, 2);
    repeat (4) send_index(10'd9);

    // peak below threshold: peak is stored and no spike occurs
    load_registers(-80 * MV, -72 * MV, -80 * MV, -90 * MV, 6 * MV, 0);
    repeat (3) send_index(10'd11);

    // recovery jump at both extremes saturates the recovery variable
    load_registers(-80 * MV, -72 * MV, -80 * MV, 35 * MV, WORD_MAX, 0);
    repeat (3) send_index(10'd12);
    load_registers(-80 * MV, -72 * MV, -80 * MV, 35 * MV, WORD_MIN, 0);
    repeat (2) send_index(10'd13);

    // full-scale potentials drive the step arithmetic into saturation
    load_registers(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, 0, 255);
    repeat (2) send_index(10'd14);
    load_registers(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 0, 255);
    repeat (2) send_index(10'd15);

    // random settings, each with a fresh set of favored neurons
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_registers(pick_potential(), pick_potential(), pick_potential(),
                     pick_potential(), pick_potential(), pick_refractory());
      foreach (pool[i]) pool[i] = izn_pkg::IDX_W'($urandom_range(0, izn_pkg::NEURONS - 1));
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (steps_sb.pending() != 0) @(posedge clk);
    repeat (4 * izn_pkg::PIPE_DEPTH) @(posedge clk);
    $display("Checked %0d neuron steps (%0d spikes) across %0d register settings",
             steps_sb.checked, steps_sb.spikes, settings + 1);
    if (steps_sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
hdl/izn_pkg.sv
hdl/izn_ram.sv
hdl/izn_cfg.sv
hdl/izn_pipe.sv
hdl/izhikevich_neuron_step.sv
hdl/izn_checker.sv
dv/izhikevich_neuron_step_tb.sv
